FILE: sv/nls_pkg.sv
// Shared types and constants for the numeric literal scanner
package nls_pkg;

  // default limit on literal length
  localparam int unsigned MaxTextDefault = 256;

  // scan phase, one-hot
  typedef enum logic [12:0] {
    PH_IDLE    = 13'b0_0000_0000_0001,
    PH_ZERO    = 13'b0_0000_0000_0010,
    PH_DEC     = 13'b0_0000_0000_0100,
    PH_DOT     = 13'b0_0000_0000_1000,
    PH_FRAC    = 13'b0_0000_0001_0000,
    PH_U       = 13'b0_0000_0010_0000,
    PH_U3      = 13'b0_0000_0100_0000,
    PH_I       = 13'b0_0000_1000_0000,
    PH_I3      = 13'b0_0001_0000_0000,
    PH_ZERO_B  = 13'b0_0010_0000_0000,
    PH_PRE_HEX = 13'b0_0100_0000_0000,
    PH_PRE_OCT = 13'b0_1000_0000_0000,
    PH_RADIX   = 13'b1_0000_0000_0000
  } phase_e;

  // number base
  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2,
    BASE_OCT = 2'd3
  } base_e;

  // token kinds
  typedef enum logic [2:0] {
    K_INT    = 3'd0,
    K_LONG   = 3'd1,
    K_BYTE   = 3'd2,
    K_UINT   = 3'd3,
    K_U32    = 3'd4,
    K_I32    = 3'd5,
    K_FLOAT  = 3'd6,
    K_DOUBLE = 3'd7
  } kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_DIGIT   = 3'd1,
    ERR_TOO_LONG   = 3'd2,
    ERR_BYTE_RANGE = 3'd3,
    ERR_U32_RANGE  = 3'd4,
    ERR_I32_RANGE  = 3'd5,
    ERR_BAD_SUFFIX = 3'd6
  } err_e;

  // value of a hex digit, 31 for anything that is not one
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    else d = 5'd31;
    return d;
  endfunction

  // numeric value of a base code
  function automatic logic [4:0] base_value(input base_e b);
    logic [4:0] v;
    unique case (b)
      BASE_DEC: v = 5'd10;
      BASE_HEX: v = 5'd16;
      BASE_BIN: v = 5'd2;
      BASE_OCT: v = 5'd8;
      default:  v = 5'd10;
    endcase
    return v;
  endfunction

  // case-insensitive letter match, lower is the lower-case letter
  function automatic logic is_letter(input logic [7:0] c, input logic [7:0] lower);
    return (c == lower) || (c == (lower & 8'hDF));
  endfunction

endpackage

FILE: sv/number_literal_scanner.sv
// Numeric literal scanner: character input register, scan step, result register
//
// Input channel: one source character (ch_i) per transfer, with start_mark_i
// high on the first digit of a literal. A NUL character marks end of text.
// Output channel: one result per finished literal with token kind, value,
// error code and the number of latest characters that were lookahead.
// Characters that do not end a literal give no result.
// Both channels use valid and stall; a transfer happens when valid is high
// and stall is low.
// The character that ends the literal sits in the input register after its
// transfer; the scan step then loads the result register from it, once the
// result register is free to take a new item.
// Throughput: one character per cycle unless the output is stalled; each
// character takes one pass through the scan step (one multiply by a constant
// base and a saturating add). When the receiver stalls, the result register
// holds its item and one more character may still be taken into the input
// register; in_stall_o rises only when that register is also full.
// Reset clears both registers' valid flags and puts the scanner in idle.
module number_literal_scanner #(
  parameter int unsigned MAX_TEXT = nls_pkg::MaxTextDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        start_mark_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic signed [63:0] token_value_o,
  output logic [2:0]  error_code_o,
  output logic [1:0]  chars_returned_o
);

  localparam logic [8:0] MaxLen = 9'(MAX_TEXT);
  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;

  // input register
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       mark_q;

  // scan state
  nls_pkg::phase_e phase_q, phase_d;
  logic [63:0]     sum_q, sum_d;
  logic            ovf_q, ovf_d;
  logic [8:0]      len_q, len_d;
  nls_pkg::base_e  base_q, base_d;

  // result register
  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [63:0] val_q;
  logic [2:0]  err_q;
  logic [1:0]  ret_q;

  logic advance, fire, in_xfer;

  // handshake
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // accumulate step: sum * base + digit, saturating
  nls_pkg::base_e base_sel;
  logic [4:0]  dig;
  logic [67:0] sum_ext, prod, acc;
  logic [63:0] acc_sum;
  logic        acc_ovf;
  logic [8:0]  len_inc1, len_inc2;
  logic [63:0] sval, uval;
  logic        len_over;

  always_comb begin
    base_sel = (phase_q == nls_pkg::PH_PRE_HEX || phase_q == nls_pkg::PH_PRE_OCT ||
                phase_q == nls_pkg::PH_RADIX) ? base_q : nls_pkg::BASE_DEC;
    dig      = nls_pkg::digit_of(ch_q);
    sum_ext  = {4'd0, sum_q};
    unique case (base_sel)
      nls_pkg::BASE_DEC: prod = (sum_ext << 3) + (sum_ext << 1);
      nls_pkg::BASE_HEX: prod = sum_ext << 4;
      nls_pkg::BASE_BIN: prod = sum_ext << 1;
      nls_pkg::BASE_OCT: prod = sum_ext << 3;
      default:           prod = sum_ext;
    endcase
    acc = prod + {63'd0, dig};
    if (ovf_q) begin
      acc_sum = sum_q;
      acc_ovf = 1'b1;
    end else if (acc[67:64] != 4'd0) begin
      acc_sum = sum_q;
      acc_ovf = 1'b1;
    end else begin
      acc_sum = acc[63:0];
      acc_ovf = 1'b0;
    end
    len_inc1 = (len_q == 9'd511) ? len_q : len_q + 9'd1;
    len_inc2 = (len_q >= 9'd510) ? 9'd511 : len_q + 9'd2;
    sval     = (ovf_q || sum_q > SMax) ? SMax : sum_q;
    uval     = ovf_q ? 64'hFFFF_FFFF_FFFF_FFFF : sum_q;
    len_over = len_q >= MaxLen;
  end

  // scan step: next state and result candidate
  logic        emit, raw, use_range;
  logic [2:0]  r_kind, r_err;
  logic [63:0] r_val, r_limit;
  logic [1:0]  r_ret;
  logic [2:0]  f_kind, f_err;
  logic [63:0] f_val;

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    ovf_d     = ovf_q;
    len_d     = len_q;
    base_d    = base_q;
    emit      = 1'b0;
    raw       = 1'b0;
    use_range = 1'b0;
    r_kind    = nls_pkg::K_INT;
    r_val     = 64'd0;
    r_err     = nls_pkg::ERR_NONE;
    r_ret     = 2'd0;
    r_limit   = 64'd0;

    if (mark_q) begin
      // new literal starts
      ovf_d  = 1'b0;
      base_d = nls_pkg::BASE_DEC;
      if (ch_q < "0" || ch_q > "9") begin
        sum_d   = 64'd0;
        len_d   = 9'd0;
        emit    = 1'b1;
        raw     = 1'b1;
        r_err   = nls_pkg::ERR_NO_DIGIT;
        r_ret   = 2'd1;
      end else begin
        sum_d   = {59'd0, dig};
        len_d   = 9'd1;
        phase_d = (ch_q == "0") ? nls_pkg::PH_ZERO : nls_pkg::PH_DEC;
      end
    end else begin
      unique case (phase_q)
        nls_pkg::PH_ZERO, nls_pkg::PH_DEC: begin
          if (phase_q == nls_pkg::PH_ZERO &&
              (nls_pkg::is_letter(ch_q, "x") || nls_pkg::is_letter(ch_q, "o"))) begin
            // radix prefix
            base_d  = nls_pkg::is_letter(ch_q, "x") ? nls_pkg::BASE_HEX : nls_pkg::BASE_OCT;
            phase_d = nls_pkg::is_letter(ch_q, "x") ? nls_pkg::PH_PRE_HEX
                                                    : nls_pkg::PH_PRE_OCT;
            sum_d   = 64'd0;
            len_d   = 9'd0;
          end else if (phase_q == nls_pkg::PH_ZERO && nls_pkg::is_letter(ch_q, "b")) begin
            phase_d = nls_pkg::PH_ZERO_B;
          end else if (ch_q >= "0" && ch_q <= "9") begin
            sum_d   = acc_sum;
            ovf_d   = acc_ovf;
            len_d   = len_inc1;
            phase_d = nls_pkg::PH_DEC;
          end else if (ch_q == ".") begin
            phase_d = nls_pkg::PH_DOT;
          end else if (nls_pkg::is_letter(ch_q, "l")) begin
            emit   = 1'b1;
            r_kind = nls_pkg::K_LONG;
            r_val  = sval;
          end else if (nls_pkg::is_letter(ch_q, "b")) begin
            emit      = 1'b1;
            use_range = 1'b1;
            r_kind    = nls_pkg::K_BYTE;
            r_val     = sval;
            r_limit   = 64'd255;
            r_err     = nls_pkg::ERR_BYTE_RANGE;
          end else if (nls_pkg::is_letter(ch_q, "u")) begin
            phase_d = nls_pkg::PH_U;
          end else if (nls_pkg::is_letter(ch_q, "i")) begin
            phase_d = nls_pkg::PH_I;
          end else begin
            emit   = 1'b1;
            r_kind = nls_pkg::K_INT;
            r_val  = sval;
            r_ret  = 2'd1;
          end
        end
        nls_pkg::PH_DOT: begin
          if (ch_q >= "0" && ch_q <= "9") begin
            len_d   = len_inc2;
            phase_d = nls_pkg::PH_FRAC;
          end else begin
            emit   = 1'b1;
            r_kind = nls_pkg::K_INT;
            r_val  = sval;
            r_ret  = 2'd2;
          end
        end
        nls_pkg::PH_FRAC: begin
          if (ch_q >= "0" && ch_q <= "9") begin
            len_d = len_inc1;
          end else begin
            emit = 1'b1;
            priority if (nls_pkg::is_letter(ch_q, "f")) begin
              r_kind = nls_pkg::K_FLOAT;
            end else if (nls_pkg::is_letter(ch_q, "d")) begin
              r_kind = nls_pkg::K_DOUBLE;
            end else begin
              r_kind = nls_pkg::K_DOUBLE;
              r_ret  = 2'd1;
            end
          end
        end
        nls_pkg::PH_U: begin
          if (ch_q == "3") begin
            phase_d = nls_pkg::PH_U3;
          end else begin
            emit   = 1'b1;
            r_kind = nls_pkg::K_UINT;
            r_val  = uval;
            r_ret  = 2'd1;
          end
        end
        nls_pkg::PH_U3: begin
          emit = 1'b1;
          if (ch_q == "2") begin
            use_range = 1'b1;
            r_kind    = nls_pkg::K_U32;
            r_val     = uval;
            r_limit   = 64'h0000_0000_FFFF_FFFF;
            r_err     = nls_pkg::ERR_U32_RANGE;
          end else begin
            r_kind = nls_pkg::K_UINT;
            r_val  = uval;
            r_ret  = 2'd2;
          end
        end
        nls_pkg::PH_I: begin
          if (ch_q == "3") begin
            phase_d = nls_pkg::PH_I3;
          end else begin
            emit   = 1'b1;
            r_kind = nls_pkg::K_INT;
            r_val  = sval;
            r_ret  = 2'd2;
          end
        end
        nls_pkg::PH_I3: begin
          emit = 1'b1;
          if (ch_q == "2") begin
            use_range = 1'b1;
            r_kind    = nls_pkg::K_I32;
            r_val     = sval;
            r_limit   = 64'h0000_0000_7FFF_FFFF;
            r_err     = nls_pkg::ERR_I32_RANGE;
          end else begin
            raw   = 1'b1;
            r_err = nls_pkg::ERR_BAD_SUFFIX;
            r_ret = 2'd2;
          end
        end
        nls_pkg::PH_ZERO_B: begin
          if (ch_q == "0" || ch_q == "1") begin
            base_d  = nls_pkg::BASE_BIN;
            sum_d   = {59'd0, dig};
            len_d   = 9'd1;
            phase_d = nls_pkg::PH_RADIX;
          end else begin
            emit      = 1'b1;
            use_range = 1'b1;
            r_kind    = nls_pkg::K_BYTE;
            r_val     = sval;
            r_limit   = 64'd255;
            r_err     = nls_pkg::ERR_BYTE_RANGE;
            r_ret     = 2'd1;
          end
        end
        nls_pkg::PH_PRE_HEX, nls_pkg::PH_PRE_OCT, nls_pkg::PH_RADIX: begin
          if (dig < nls_pkg::base_value(base_q)) begin
            sum_d   = acc_sum;
            ovf_d   = acc_ovf;
            len_d   = len_inc1;
            phase_d = nls_pkg::PH_RADIX;
          end else if (phase_q != nls_pkg::PH_RADIX) begin
            // prefix with no digit after it
            emit  = 1'b1;
            raw   = 1'b1;
            r_err = nls_pkg::ERR_NO_DIGIT;
            r_ret = 2'd1;
          end else if (nls_pkg::is_letter(ch_q, "l")) begin
            emit   = 1'b1;
            r_kind = nls_pkg::K_LONG;
            r_val  = sval;
          end else begin
            emit   = 1'b1;
            r_kind = nls_pkg::K_INT;
            r_val  = sval;
            r_ret  = 2'd1;
          end
        end
        default: begin
          // idle: characters outside a literal are ignored
          phase_d = nls_pkg::PH_IDLE;
        end
      endcase
    end

    if (emit) begin
      phase_d = nls_pkg::PH_IDLE;
    end

    // final result fields: raw errors first, then length check, then range check
    priority if (raw) begin
      f_kind = nls_pkg::K_INT;
      f_val  = 64'd0;
      f_err  = r_err;
    end else if (len_over) begin
      f_kind = nls_pkg::K_INT;
      f_val  = 64'd0;
      f_err  = nls_pkg::ERR_TOO_LONG;
    end else if (use_range && r_val > r_limit) begin
      f_kind = nls_pkg::K_INT;
      f_val  = 64'd0;
      f_err  = r_err;
    end else begin
      f_kind = r_kind;
      f_val  = r_val;
      f_err  = nls_pkg::ERR_NONE;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q   <= ch_i;
      mark_q <= start_mark_i;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nls_pkg::PH_IDLE;
      sum_q   <= 64'd0;
      ovf_q   <= 1'b0;
      len_q   <= 9'd0;
      base_q  <= nls_pkg::BASE_DEC;
    end else if (fire) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
      base_q  <= base_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q <= f_kind;
      val_q  <= f_val;
      err_q  <= f_err;
      ret_q  <= r_ret;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign token_kind_o     = kind_q;
  assign token_value_o    = val_q;
  assign error_code_o     = err_q;
  assign chars_returned_o = ret_q;

endmodule
